// ===== rtl/gde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian density evaluator package
// Fixed-point constants, register indexes and the exponential lookup table.
// ----------------------------------------------------------------------------
package gde_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int EXP_TABLE_BITS = 6;

   localparam int TBITS       = (EXP_TABLE_BITS < FRAC_BITS) ? EXP_TABLE_BITS : FRAC_BITS;
   localparam int RBITS       = FRAC_BITS - TBITS;
   localparam int TABLE_SIZE  = 1 << TBITS;
   localparam int T_W         = FRAC_BITS + 5;
   localparam int YM_HI_W     = T_W - 1;
   localparam int Y_W         = FRAC_BITS + 6;
   localparam int K_W         = Y_W - FRAC_BITS;
   localparam int RL_W        = FRAC_BITS + 32;
   localparam int PROD_W      = 96;
   localparam int FLUSH_SHIFT = 3 * FRAC_BITS + 5;
   localparam int PIPE_DEPTH  = 11;

   localparam logic [30:0]          LOG2E_FRAC = 31'd1901360723;
   localparam logic [31:0]          LN2_Q32    = 32'd2977044472;
   localparam logic [32:0]          ONE_Q32    = 33'h1_0000_0000;
   localparam logic [FRAC_BITS-1:0] R_MASK     = FRAC_BITS'((64'd1 << RBITS) - 64'd1);

   typedef enum logic [1:0] {
      REG_MEAN_POSITION        = 2'd0,
      REG_INVERSE_TWO_VARIANCE = 2'd1,
      REG_DENSITY_SCALE        = 2'd2
   } csr_index_type;

   typedef logic [32:0] exp_table_type [TABLE_SIZE];

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bit_mask;
      v        = value;
      r        = 64'd0;
      bit_mask = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (bit_mask > v) begin
            bit_mask = bit_mask >> 2;
         end
      end
      for (int n = 0; n < 32; n++) begin
         if (bit_mask != 64'd0) begin
            if (v >= r + bit_mask) begin
               v = v - (r + bit_mask);
               r = (r >> 1) + bit_mask;
            end else begin
               r = r >> 1;
            end
            bit_mask = bit_mask >> 2;
         end
      end
      return r;
   endfunction

   // Entry i is the product of 2^(-2^-j) over the set bits of i, truncated at each step.
   function automatic exp_table_type build_exp_table();
      exp_table_type tbl;
      logic [63:0]   c;
      logic [63:0]   tab;
      logic [127:0]  prod;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tab = 64'h1_0000_0000;
         c   = isqrt64(64'd1 << 63);
         for (int j = 1; j <= TBITS; j++) begin
            if (((i >> (TBITS - j)) & 1) != 0) begin
               prod = 128'(tab) * 128'(c);
               tab  = prod[95:32];
            end
            c = isqrt64(c << 32);
         end
         tbl[i] = tab[32:0];
      end
      return tbl;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

// ===== rtl/gaussian_density_evaluator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian density evaluator core
// Returns density_scale * exp(-inverse_two_variance * (x - mean_position)^2)
// for each node position, with a table-based base-two exponential.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_node_position
//   rsp      out        rsp_valid/rsp_ready  rsp_density, rsp_saturated
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One transfer can enter every cycle unless the output stall has filled the
// pipeline; its depth follows the multiplier chain from square to scaling.
// Reset clears the stage valid bits and loads the register reset values.
// Each stage holds while its successor is full and stalled, and an empty stage
// accepts new data, so bubbles close up under an output stall.
// ----------------------------------------------------------------------------
module gaussian_density_evaluator_core
   import gde_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  signed [31:0]  req_node_position,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic        [31:0]  rsp_density,
   output logic                rsp_saturated,
   input  wire                 csr_write_enable,
   input  wire         [1:0]   csr_index,
   input  wire         [31:0]  csr_write_data
);

   logic signed [31:0] mean_ff;
   logic        [31:0] inv_var_ff;
   logic        [31:0] scale_ff;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] stage_ready;

   logic        [31:0]          ad_ff,    ad_in;
   logic signed [32:0]          dx;
   logic        [63:0]          sq_ff,    sq_in;
   logic        [63:0]          plo_ff,   plo_in;
   logic        [63:0]          phi_ff,   phi_in;
   logic        [PROD_W-1:0]    prod;
   logic        [T_W-1:0]       t4_ff,    t4_in;
   logic        [T_W-1:0]       t5_ff;
   logic        [T_W+30:0]      ym;
   logic        [YM_HI_W-1:0]   ym_hi_ff, ym_hi_in;
   logic        [Y_W-1:0]       y;
   logic        [K_W-1:0]       k_in;
   logic        [K_W-1:0]       k_ff [6:PIPE_DEPTH-1];
   logic        [TBITS-1:0]     idx_ff,   idx_in;
   logic        [FRAC_BITS-1:0] r_ff,     r_in;
   logic        [32:0]          tab7_ff,  tab7_in;
   logic        [32:0]          tab8_ff;
   logic        [RL_W-1:0]      rl_ff,    rl_in;
   logic        [32:0]          corr_ff,  corr_in;
   logic        [65:0]          mprod;
   logic        [32:0]          m_ff,     m_in;
   logic        [64:0]          pprod;
   logic        [32:0]          p_ff,     p_in;
   logic        [32:0]          ps;
   logic                        small_in;
   logic                        small_ff [4:PIPE_DEPTH-1];
   logic        [31:0]          dens_ff,  dens_in;
   logic                        sat_ff,   sat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff    <= '0;
         inv_var_ff <= 32'd32768;
         scale_ff   <= 32'd26145;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MEAN_POSITION:        mean_ff    <= $signed(csr_write_data);
            REG_INVERSE_TWO_VARIANCE: inv_var_ff <= csr_write_data;
            REG_DENSITY_SCALE:        scale_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      stage_ready[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      dx       = 33'(req_node_position) - 33'(mean_ff);
      ad_in    = dx[32] ? 32'(-dx) : dx[31:0];
      sq_in    = 64'(ad_ff) * 64'(ad_ff);
      plo_in   = 64'(inv_var_ff) * 64'(sq_ff[31:0]);
      phi_in   = 64'(inv_var_ff) * 64'(sq_ff[63:32]);
      prod     = PROD_W'(plo_ff) + {phi_ff, 32'd0};
      small_in = (prod[PROD_W-1:FLUSH_SHIFT] == '0);
      t4_in    = prod[2*FRAC_BITS +: T_W];
      ym       = (T_W+31)'(t4_ff) * (T_W+31)'(LOG2E_FRAC);
      ym_hi_in = ym[T_W+30:32];
      y        = Y_W'(t5_ff) + Y_W'(ym_hi_ff);
      k_in     = y[Y_W-1:FRAC_BITS];
      idx_in   = y[FRAC_BITS-1 -: TBITS];
      r_in     = y[FRAC_BITS-1:0] & R_MASK;
      tab7_in  = EXP_TABLE[idx_ff];
      rl_in    = RL_W'(r_ff) * RL_W'(LN2_Q32);
      corr_in  = ONE_Q32 - {1'b0, rl_ff[RL_W-1:FRAC_BITS]};
      mprod    = 66'(tab8_ff) * 66'(corr_ff);
      m_in     = mprod[64:32];
      pprod    = 65'(scale_ff) * 65'(m_ff);
      p_in     = pprod[64:32];
      ps       = p_ff >> k_ff[PIPE_DEPTH-1];
      sat_in   = small_ff[PIPE_DEPTH-1] && ps[32];
      if (!small_ff[PIPE_DEPTH-1]) begin
         dens_in = '0;
      end else if (ps[32]) begin
         dens_in = '1;
      end else begin
         dens_in = ps[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         ad_ff <= ad_in;
      end
      if (stage_ready[1]) begin
         sq_ff <= sq_in;
      end
      if (stage_ready[2]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (stage_ready[3]) begin
         t4_ff       <= t4_in;
         small_ff[4] <= small_in;
      end
      if (stage_ready[4]) begin
         t5_ff       <= t4_ff;
         ym_hi_ff    <= ym_hi_in;
         small_ff[5] <= small_ff[4];
      end
      if (stage_ready[5]) begin
         k_ff[6]     <= k_in;
         idx_ff      <= idx_in;
         r_ff        <= r_in;
         small_ff[6] <= small_ff[5];
      end
      if (stage_ready[6]) begin
         tab7_ff <= tab7_in;
         rl_ff   <= rl_in;
      end
      if (stage_ready[7]) begin
         tab8_ff <= tab7_ff;
         corr_ff <= corr_in;
      end
      if (stage_ready[8]) begin
         m_ff <= m_in;
      end
      if (stage_ready[9]) begin
         p_ff <= p_in;
      end
      for (int i = 7; i < PIPE_DEPTH; i++) begin
         if (stage_ready[i-1]) begin
            k_ff[i]     <= k_ff[i-1];
            small_ff[i] <= small_ff[i-1];
         end
      end
      if (stage_ready[PIPE_DEPTH-1]) begin
         dens_ff <= dens_in;
         sat_ff  <= sat_in;
      end
   end

   assign req_ready     = stage_ready[0];
   assign rsp_valid     = valid_ff[PIPE_DEPTH-1];
   assign rsp_density   = dens_ff;
   assign rsp_saturated = sat_ff;

   a_no_saturation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_saturated)
      else $error("density saturated although the exponential factor is at most one");

   a_density_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_density <= scale_ff))
      else $error("density exceeds the normalization scale");

   a_empty_output_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input not ready while the output stage is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire
